FILE: rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue cells and top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  localparam int unsigned CountOutW = 5;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic signed [31:0]     value_out;
    logic [CountOutW-1:0]   count;
  } out_item_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic               insert;
    logic               remove;
    logic signed [31:0] value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/sorted_priority_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Ascending priority queue built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Cells compare and shift in parallel; each accepted result is registered.
// Throughput: one item per cycle while the output register is free or read.
// Insert, remove and clear all complete in the cycle they are accepted.
// Reset clears the count and the output valid; cell entries are not reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]     count_q, count_d;
  logic                out_valid_q;
  out_item_t           out_item_q, out_item_d;
  logic                accept;
  logic                full, empty;
  cell_ctrl_t          ctrl;
  logic [CntW+CountOutW-1:0] count_ext;

  logic               less   [CAPACITY];
  logic signed [31:0] entry  [CAPACITY];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = count_q == CntW'(CAPACITY);
  assign empty      = count_q == '0;

  always_comb begin
    ctrl.insert = accept && (in_item_i.cmd == CMD_INSERT) && !full;
    ctrl.remove = accept && (in_item_i.cmd == CMD_REMOVE) && !empty;
    ctrl.value  = in_item_i.value;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               left_less;
    logic signed [31:0] left_entry, right_entry;
    if (i == 0) begin : g_first
      assign left_less  = 1'b1;
      assign left_entry = '0;
    end else begin : g_mid
      assign left_less  = less[i-1];
      assign left_entry = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end
    spq_cell #(
      .INDEX (i),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .left_less_i   (left_less),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .less_o        (less[i]),
      .entry_o       (entry[i])
    );
  end

  always_comb begin
    count_d              = count_q;
    out_item_d.status    = ST_OK;
    out_item_d.value_out = '0;
    case (in_item_i.cmd)
      CMD_INSERT: begin
        if (full) begin
          out_item_d.status = ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (empty) begin
          out_item_d.status = ST_EMPTY;
        end else begin
          out_item_d.value_out = entry[0];
          count_d = count_q - 1'b1;
        end
      end
      CMD_CLEAR: begin
        if (empty) begin
          out_item_d.status = ST_EMPTY;
        end
        count_d = '0;
      end
      default: begin
      end
    endcase
    count_ext        = {{CountOutW{1'b0}}, count_d};
    out_item_d.count = count_ext[CountOutW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

FILE: rtl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares its entry with the broadcast value
// and either holds, takes the new value, or shifts from a neighbor.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 5
) (
  input  wire logic               clk_i,
  input  wire cell_ctrl_t         ctrl_i,
  input  wire logic [CNT_W-1:0]   count_i,
  input  wire logic               left_less_i,
  input  wire logic signed [31:0] left_entry_i,
  input  wire logic signed [31:0] right_entry_i,
  output logic                    less_o,
  output logic signed [31:0]      entry_o
);

  logic signed [31:0] entry_q, entry_d;
  logic               in_use;

  assign in_use  = CNT_W'(INDEX) < count_i;
  assign less_o  = in_use && (entry_q < ctrl_i.value);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (!less_o) begin
        entry_d = left_less_i ? ctrl_i.value : left_entry_i;
      end
    end else if (ctrl_i.remove) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
`default_nettype wire

FILE: test/sorted_priority_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_tb
// Drives insert, remove, clear and spare commands into the sorted priority
// queue and checks every reply against a shadow copy of the sorted contents.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int unsigned Capacity   = 16;
  localparam int unsigned RandItems  = 400;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 250;
  localparam logic [1:0]  CmdSpare   = 2'd3;

  typedef struct {
    in_item_t    item;
    int unsigned gap;
  } send_entry_t;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;

  send_entry_t        cmd_backlog[$];
  out_item_t          queue_replies[$];
  logic signed [31:0] shadow_q[$];

  int unsigned send_idle;
  int unsigned recv_wait;
  int unsigned hold_cnt;
  int unsigned hold_hits;
  int unsigned cycle_cnt;
  int unsigned sent_cnt;
  int unsigned results_seen;
  int unsigned err_cnt;
  int unsigned full_hits;
  int unsigned empty_hits;
  int unsigned peak_depth;

  sorted_priority_queue_top #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned idle_draw(int unsigned idx);
    return ((idx / 40) % 3 == 0) ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 3))
      0: begin
        v = $urandom_range(0, 16);
        v = v - 32'sd8;
      end
      1: begin
        if ($urandom_range(0, 1) == 1) begin
          v = 32'h7fff_ffff - $urandom_range(0, 3);
        end else begin
          v = 32'h8000_0000 + $urandom_range(0, 3);
        end
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic add_cmd(logic [1:0] c, logic signed [31:0] v);
    send_entry_t e;
    e.item.cmd   = c;
    e.item.value = v;
    e.gap        = idle_draw(cmd_backlog.size());
    cmd_backlog.push_back(e);
  endtask

  // shadow of the sorted contents, one reply per command
  task automatic compute_reply(in_item_t it);
    out_item_t   r;
    int unsigned pos;
    r = '0;
    r.status = ST_OK;
    case (it.cmd)
      CMD_INSERT: begin
        if (shadow_q.size() >= Capacity) begin
          r.status = ST_FULL;
          full_hits++;
        end else begin
          pos = 0;
          while (pos < shadow_q.size() && shadow_q[pos] < it.value) pos++;
          shadow_q.insert(pos, it.value);
        end
      end
      CMD_REMOVE: begin
        if (shadow_q.size() == 0) begin
          r.status = ST_EMPTY;
          empty_hits++;
        end else begin
          r.value_out = shadow_q.pop_front();
        end
      end
      CMD_CLEAR: begin
        if (shadow_q.size() == 0) begin
          r.status = ST_EMPTY;
          empty_hits++;
        end
        shadow_q.delete();
      end
      default: begin
      end
    endcase
    r.count = CountOutW'(shadow_q.size());
    if (shadow_q.size() > peak_depth) peak_depth = shadow_q.size();
    queue_replies.push_back(r);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    send_entry_t e;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      in_item   <= '0;
      send_idle <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        compute_reply(in_item);
        sent_cnt++;
      end
      if (send_idle != 0) begin
        send_idle <= send_idle - 1;
        in_valid  <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        e = cmd_backlog.pop_front();
        in_item   <= e.item;
        in_valid  <= 1'b1;
        send_idle <= e.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the queue backs up into the input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt  <= 0;
      hold_hits <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if ((hold_hits == 0 && results_seen >= 60) ||
                 (hold_hits == 1 && results_seen >= 260)) begin
      hold_cnt  <= HoldCycles;
      hold_hits <= hold_hits + 1;
    end
  end

  // receiver and reply check
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t   want;
    int unsigned w;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      w = (recv_wait != 0) ? recv_wait - 1 : 0;
      if (out_valid && out_ready) begin
        results_seen++;
        if (queue_replies.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("unexpected reply: status %0d value %0d count %0d",
                     out_item.status, out_item.value_out, out_item.count);
          end
        end else begin
          want = queue_replies.pop_front();
          if (out_item.status !== want.status || out_item.value_out !== want.value_out ||
              out_item.count !== want.count) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("reply %0d mismatch: exp status %0d value %0d count %0d, ",
                       results_seen, want.status, want.value_out, want.count,
                       "got status %0d value %0d count %0d",
                       out_item.status, out_item.value_out, out_item.count);
            end
          end
        end
        w = idle_draw(results_seen);
      end
      recv_wait <= w;
      out_ready <= (w == 0) && (hold_cnt == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout: %0d replies still pending", queue_replies.size());
      $display("sorted_priority_queue_top verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned mode;
    int unsigned ins_pct;
    int unsigned roll;

    // directed corners
    add_cmd(CMD_REMOVE, 32'sd5);
    add_cmd(CMD_CLEAR, 32'sd0);
    add_cmd(CmdSpare, $urandom());
    add_cmd(CMD_INSERT, 32'h7fff_ffff);
    add_cmd(CMD_INSERT, 32'h8000_0000);
    add_cmd(CMD_INSERT, 32'sd0);
    add_cmd(CMD_INSERT, -32'sd1);
    add_cmd(CMD_INSERT, 32'sd1);
    add_cmd(CMD_INSERT, -32'sd1);
    for (int i = 0; i < 7; i++) add_cmd(CMD_INSERT, pick_value());
    add_cmd(CMD_INSERT, 32'sd3);
    add_cmd(CmdSpare, $urandom());
    add_cmd(CMD_REMOVE, 32'sd0);
    add_cmd(CMD_REMOVE, 32'sd0);
    add_cmd(CMD_CLEAR, 32'sd0);
    add_cmd(CMD_REMOVE, 32'sd0);

    // random segments biased toward filling, draining or mixing
    mode = 0;
    for (int k = 0; k < RandItems; k++) begin
      if (k % 30 == 0) mode = $urandom_range(0, 2);
      ins_pct = (mode == 0) ? 80 : (mode == 1) ? 30 : 55;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        add_cmd(CmdSpare, $urandom());
      end else if (roll < 5) begin
        add_cmd(CMD_CLEAR, $urandom());
      end else if (roll < ins_pct) begin
        add_cmd(CMD_INSERT, pick_value());
      end else begin
        add_cmd(CMD_REMOVE, $urandom());
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || in_valid) @(posedge clk_i);
    while (queue_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("sent %0d commands, checked %0d replies, %0d errors", sent_cnt, results_seen,
             err_cnt);
    $display("full rejects %0d, empty replies %0d, peak depth %0d", full_hits, empty_hits,
             peak_depth);
    if (err_cnt == 0) begin
      $display("sorted_priority_queue_top verification clean");
    end else begin
      $display("sorted_priority_queue_top verification failed");
    end
    $finish;
  end

endmodule
